### src/nsv_pkg.sv
package nsv_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;

  localparam logic [23:0] TEXT_GLL = 24'h474C4C;
  localparam logic [23:0] TEXT_GGA = 24'h474741;
  localparam logic [23:0] TEXT_RMC = 24'h524D43;

  localparam logic [2:0] POS_MAX = 3'd7;
  localparam logic [1:0] DIGIT_COUNT_MAX = 2'd3;
  localparam logic [1:0] DIGITS_EXPECTED = 2'd2;

  typedef enum logic [1:0] {
    TYPE_GLL,
    TYPE_GGA,
    TYPE_RMC,
    TYPE_UNKNOWN
  } nsv_type_t;

  typedef enum logic [2:0] {
    REASON_OK,
    REASON_PREFIX,
    REASON_TYPE,
    REASON_DIGITS,
    REASON_MISMATCH
  } nsv_reason_t;

  typedef struct packed {
    logic [2:0]  char_position;
    logic        prefix_good;
    logic [23:0] type_chars;
    logic [7:0]  running_xor;
    logic        star_seen;
    logic [1:0]  digit_count;
    logic [7:0]  received_sum;
    logic        digit_bad;
  } nsv_state_t;

  typedef struct packed {
    logic        valid_res;
    nsv_type_t   sentence_type;
    nsv_reason_t reason;
    logic [7:0]  computed_sum;
  } nsv_result_t;

  localparam nsv_state_t STATE_RESET = '{
    char_position: 3'd0,
    prefix_good:   1'b1,
    type_chars:    24'd0,
    running_xor:   8'd0,
    star_seen:     1'b0,
    digit_count:   2'd0,
    received_sum:  8'd0,
    digit_bad:     1'b0
  };

  // expected prefix character at positions zero to two
  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CHAR_DOLLAR;
      2'd1:    c = CHAR_G;
      default: c = CHAR_P;
    endcase
    return c;
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

### src/nsv_step.sv
module nsv_step
  import nsv_pkg::*;
(
  input  nsv_state_t  st,
  input  logic [7:0]  byte_in,
  input  logic        eol,
  output nsv_state_t  st_nxt,
  output nsv_result_t res
);

  nsv_state_t  upd;
  logic [4:0]  hex;
  nsv_type_t   type_code;
  nsv_reason_t reason;

  always_comb begin
    upd = st;
    hex = hex_decode(byte_in);

    if (st.char_position < 3'd3) begin
      if (byte_in != prefix_char(st.char_position[1:0])) begin
        upd.prefix_good = 1'b0;
      end
    end else if (st.char_position < 3'd6) begin
      upd.type_chars = {st.type_chars[15:0], byte_in};
    end

    if (!st.star_seen) begin
      if (byte_in == CHAR_STAR) begin
        upd.star_seen = 1'b1;
      end else if (st.char_position != 3'd0) begin
        upd.running_xor = st.running_xor ^ byte_in;
      end
    end else begin
      if (st.digit_count != DIGIT_COUNT_MAX) begin
        upd.digit_count = st.digit_count + 2'd1;
      end
      if (!hex[4]) begin
        upd.digit_bad = 1'b1;
      end else begin
        upd.received_sum = {st.received_sum[3:0], hex[3:0]};
      end
    end

    if (st.char_position != POS_MAX) begin
      upd.char_position = st.char_position + 3'd1;
    end

    if (upd.char_position < 3'd6) begin
      type_code = TYPE_UNKNOWN;
    end else if (upd.type_chars == TEXT_GLL) begin
      type_code = TYPE_GLL;
    end else if (upd.type_chars == TEXT_GGA) begin
      type_code = TYPE_GGA;
    end else if (upd.type_chars == TEXT_RMC) begin
      type_code = TYPE_RMC;
    end else begin
      type_code = TYPE_UNKNOWN;
    end

    if (!upd.prefix_good || upd.char_position < 3'd3) begin
      reason = REASON_PREFIX;
    end else if (type_code == TYPE_UNKNOWN) begin
      reason = REASON_TYPE;
    end else if (!upd.star_seen || upd.digit_count != DIGITS_EXPECTED || upd.digit_bad) begin
      reason = REASON_DIGITS;
    end else if (upd.received_sum != upd.running_xor) begin
      reason = REASON_MISMATCH;
    end else begin
      reason = REASON_OK;
    end

    res.valid_res     = (reason == REASON_OK);
    res.sentence_type = type_code;
    res.reason        = reason;
    res.computed_sum  = upd.running_xor;

    // the last byte of a sentence leaves the checker ready for the next one
    st_nxt = eol ? STATE_RESET : upd;
  end

endmodule

### src/nmea_sentence_validator_core.sv
// Checks an NMEA 0183 sentence delivered one character per request, with the last character
// flagged by in_end_of_line. The "$GP" prefix and the GLL, GGA or RMC type are checked, the
// bytes between '$' and the first '*' are XORed and compared with two hex digits (either case)
// after the '*'. One result (pass flag, type, reason, computed checksum) appears on the out_
// channel for each flagged character in the cycle after it is accepted; other characters give no
// result. A character is taken every cycle: the running state updates in a single pass and the
// result sits in one output register, so only a last character arriving while a previous result
// is still stalled has to wait.
module nmea_sentence_validator_core
  import nsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_req,
  input  logic       in_end_of_line,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res,
  output logic [1:0] out_sentence_type,
  output logic [2:0] out_reason,
  output logic [7:0] out_computed_sum
);

  nsv_state_t  state_r, state_nxt;
  nsv_result_t res_nxt, res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_accept;
  logic        out_take;

  nsv_step u_step (
    .st      (state_r),
    .byte_in (in_byte_req),
    .eol     (in_end_of_line),
    .st_nxt  (state_nxt),
    .res     (res_nxt)
  );

  // only a result-producing request needs room in the output register
  assign in_stall  = in_end_of_line && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept && in_end_of_line) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_end_of_line) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = res_r.valid_res;
  assign out_sentence_type = res_r.sentence_type;
  assign out_reason        = res_r.reason;
  assign out_computed_sum  = res_r.computed_sum;

`ifndef SYNTHESIS
  a_pass_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.valid_res == (res_r.reason == REASON_OK)))
    else $error("pass flag disagrees with reason");

  a_pass_has_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.reason == REASON_OK) |-> (res_r.sentence_type != TYPE_UNKNOWN))
    else $error("passing sentence with unknown type");

  a_result_from_eol: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept && in_end_of_line))
    else $error("result without a last character");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_end_of_line) |=> (state_r == STATE_RESET))
    else $error("state not cleared after sentence end");
`endif

endmodule

### dv/nmea_sentence_validator_core_test.sv
module nmea_sentence_validator_core_test;
  import nsv_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_CHARS = 800;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [7:0] FILL_MARK = "?";
  localparam logic [7:0] LEADER [0:2] = '{CHAR_DOLLAR, CHAR_G, CHAR_P};
  localparam nsv_result_t NO_REPORT = '0;

  typedef struct {
    string       text;
    logic [7:0]  fill;
    bit          typed;
    nsv_result_t report;
  } sentence_row_t;

  typedef struct {
    bit          typed;
    nsv_result_t report;
  } known_report_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte_req;
  logic       in_end_of_line;
  logic       out_valid;
  logic       out_stall;
  logic       out_valid_res;
  logic [1:0] out_sentence_type;
  logic [2:0] out_reason;
  logic [7:0] out_computed_sum;

  nsv_state_t    sentence = STATE_RESET;
  nsv_result_t   expected_reports [$];
  known_report_t known_reports [$];
  logic [7:0]    chars [$];
  bit            failed = 1'b0;
  bit            quiet = 1'b0;
  int            results_seen = 0;
  int            sent_chars = 0;
  int            idle_cycles = 0;

  // '?' in the text is sent as the row's fill byte
  sentence_row_t directed_rows [0:19] = '{
    '{"$GPGLL*50", 8'h00, 1'b1, '{1'b1, TYPE_GLL, REASON_OK, 8'h50}},
    '{"$GPGGA*56", 8'h00, 1'b1, '{1'b1, TYPE_GGA, REASON_OK, 8'h56}},
    '{"$GPRMC*4b", 8'h00, 1'b1, '{1'b1, TYPE_RMC, REASON_OK, 8'h4B}},
    '{"$GPRMC*4B", 8'h00, 1'b1, '{1'b1, TYPE_RMC, REASON_OK, 8'h4B}},
    '{"$GPGLL*51", 8'h00, 1'b1, '{1'b0, TYPE_GLL, REASON_MISMATCH, 8'h50}},
    '{"$", 8'h00, 1'b1, '{1'b0, TYPE_UNKNOWN, REASON_PREFIX, 8'h00}},
    '{"$G", 8'h00, 1'b1, '{1'b0, TYPE_UNKNOWN, REASON_PREFIX, 8'h47}},
    '{"$GPGL", 8'h00, 1'b0, NO_REPORT},
    '{"#GPGLL*50", 8'h00, 1'b1, '{1'b0, TYPE_GLL, REASON_PREFIX, 8'h50}},
    '{"*GPGLL", 8'h00, 1'b0, NO_REPORT},
    '{"$GP*GA", 8'h00, 1'b0, NO_REPORT},
    '{"$GPGLL,1,2", 8'h00, 1'b0, NO_REPORT},
    '{"$GPGLL*5", 8'h00, 1'b0, NO_REPORT},
    '{"$GPGLL*500", 8'h00, 1'b0, NO_REPORT},
    '{"$GPGLL**5", 8'h00, 1'b0, NO_REPORT},
    '{"$GPXYZ*00", 8'h00, 1'b0, NO_REPORT},
    '{"$GP?LL*50", 8'h00, 1'b0, NO_REPORT},
    '{"$GPGGA,?*a8", 8'hFF, 1'b0, NO_REPORT},
    '{"$GPGGA*5g", 8'h00, 1'b0, NO_REPORT},
    '{"$GPRMC,123519,A,4807.038,N*6f", 8'h00, 1'b0, NO_REPORT}
  };

  nmea_sentence_validator_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_req      (in_byte_req),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_valid_res    (out_valid_res),
    .out_sentence_type(out_sentence_type),
    .out_reason       (out_reason),
    .out_computed_sum (out_computed_sum)
  );

  always #6 clk = ~clk;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'("0") + 8'(n);
    end else begin
      c = ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    end
    return c;
  endfunction

  // follows one accepted request and queues the report due on the last character
  function automatic void track_char(input logic [7:0] c, input logic eol);
    logic [2:0]  pos;
    logic [2:0]  count;
    int          v;
    nsv_type_t   kind;
    nsv_reason_t why;
    nsv_result_t r;
    pos = sentence.char_position;
    if (pos < 3'd3) begin
      if (c != LEADER[pos]) sentence.prefix_good = 1'b0;
    end else if (pos < 3'd6) begin
      sentence.type_chars = {sentence.type_chars[15:0], c};
    end
    if (!sentence.star_seen) begin
      if (c == CHAR_STAR) sentence.star_seen = 1'b1;
      else if (pos != 3'd0) sentence.running_xor ^= c;
    end else begin
      v = nibble_of(c);
      if (sentence.digit_count != DIGIT_COUNT_MAX) sentence.digit_count++;
      if (v < 0) sentence.digit_bad = 1'b1;
      else sentence.received_sum = {sentence.received_sum[3:0], 4'(v)};
    end
    count = (pos == POS_MAX) ? POS_MAX : pos + 3'd1;
    sentence.char_position = count;
    if (eol) begin
      if (count < 3'd6) kind = TYPE_UNKNOWN;
      else if (sentence.type_chars == TEXT_GLL) kind = TYPE_GLL;
      else if (sentence.type_chars == TEXT_GGA) kind = TYPE_GGA;
      else if (sentence.type_chars == TEXT_RMC) kind = TYPE_RMC;
      else kind = TYPE_UNKNOWN;
      if (!sentence.prefix_good || count < 3'd3) why = REASON_PREFIX;
      else if (kind == TYPE_UNKNOWN) why = REASON_TYPE;
      else if (!sentence.star_seen || sentence.digit_count != DIGITS_EXPECTED ||
               sentence.digit_bad) why = REASON_DIGITS;
      else if (sentence.received_sum != sentence.running_xor) why = REASON_MISMATCH;
      else why = REASON_OK;
      r.valid_res = (why == REASON_OK);
      r.sentence_type = kind;
      r.reason = why;
      r.computed_sum = sentence.running_xor;
      expected_reports = {expected_reports, r};
      sentence = STATE_RESET;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s expected %0h got %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // report check comes first: a report leaving now belongs to an earlier request
  always @(posedge clk) begin : monitor
    nsv_result_t   want;
    known_report_t known;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          $display("%0t unexpected report: type %0d reason %0d sum %0h", $time,
                   out_sentence_type, out_reason, out_computed_sum);
          failed = 1'b1;
        end else begin
          want = expected_reports.pop_front();
          if (known_reports.size() != 0) begin
            known = known_reports.pop_front();
            if (known.typed) want = known.report;
          end
          check_field("valid_res", want.valid_res, out_valid_res);
          check_field("sentence_type", want.sentence_type, out_sentence_type);
          check_field("reason", want.reason, out_reason);
          check_field("computed_sum", want.computed_sum, out_computed_sum);
        end
      end
      if (in_valid && !in_stall) track_char(in_byte_req, in_end_of_line);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("nmea_sentence_validator_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int r;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      // one long hold-off so the output fills and the input backs up
      if (!held && results_seen >= 15) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eol);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_req <= c;
    in_end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    sent_chars++;
  endtask

  task automatic send_sentence(input bit typed, input nsv_result_t report);
    known_report_t known;
    known.typed = typed;
    known.report = report;
    known_reports = {known_reports, known};
    quiet = ($urandom_range(0, 4) == 0);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // mostly well-formed sentences with random fields, the rest broken or plain noise
  function automatic void build_random_sentence();
    int mode;
    int len;
    logic [7:0] c;
    logic [7:0] sum;
    logic [23:0] kind;
    chars.delete();
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) c = CHAR_STAR;
        chars = {chars, c};
      end
      return;
    end
    chars = {chars, CHAR_DOLLAR};
    chars = {chars, CHAR_G};
    chars = {chars, CHAR_P};
    case ($urandom_range(0, 7))
      0:       kind = 24'($urandom_range(0, 24'hFFFFFF));
      1, 2:    kind = TEXT_GLL;
      3, 4:    kind = TEXT_GGA;
      default: kind = TEXT_RMC;
    endcase
    chars = {chars, kind[23:16]};
    chars = {chars, kind[15:8]};
    chars = {chars, kind[7:0]};
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (len) begin
      c = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      if (c == CHAR_STAR) c = ",";
      chars = {chars, c};
    end
    if (mode < 9) chars[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
    if (mode < 13 && mode >= 9) return;
    sum = '0;
    for (int i = 1; i < chars.size(); i++) sum ^= chars[i];
    chars = {chars, CHAR_STAR};
    chars = {chars, hex_char(sum[7:4])};
    chars = {chars, hex_char(sum[3:0])};
    if (mode >= 13 && mode < 21) begin
      chars[chars.size() - 1] = hex_char(sum[3:0] + 4'($urandom_range(1, 15)));
    end else if (mode >= 21 && mode < 26) begin
      void'(chars.pop_back());
    end else if (mode >= 26 && mode < 31) begin
      chars = {chars, hex_char(4'($urandom_range(0, 15)))};
    end else if (mode >= 31 && mode < 36) begin
      chars[chars.size() - $urandom_range(1, 2)] = 8'($urandom_range(0, 255));
    end
  endfunction

  initial begin : stimulus
    logic [7:0] c;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte_req <= '0;
    in_end_of_line <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[k]) begin
      chars.delete();
      for (int i = 0; i < directed_rows[k].text.len(); i++) begin
        c = directed_rows[k].text[i];
        chars = {chars, (c == FILL_MARK) ? directed_rows[k].fill : c};
      end
      send_sentence(directed_rows[k].typed, directed_rows[k].report);
    end
    while (sent_chars < RANDOM_CHARS) begin
      build_random_sentence();
      send_sentence(1'b0, NO_REPORT);
    end
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("nmea_sentence_validator_core: match");
    end else begin
      $display("nmea_sentence_validator_core: mismatch");
    end
    $finish;
  end

endmodule
